### hw/rtl/usxe_pkg.sv
// Types, byte constants and helper functions shared by the escaper modules.
package usxe_pkg;

    // Byte ranges and special characters
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;

    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_LT   = 8'h3C;
    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_QUOT = 8'h22;
    localparam logic [7:0] CHAR_APOS = 8'h27;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    // U+FFFD encoded as UTF-8
    localparam logic [7:0] REPL_0    = 8'hEF;
    localparam logic [7:0] REPL_1    = 8'hBF;
    localparam logic [7:0] REPL_2    = 8'hBD;

    // Longest literal run of one job (an entity such as &quot;)
    localparam int unsigned MID_MAX  = 6;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_text;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_TEXT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_byte_class;

    // Literal run: bytes[0] goes out first
    typedef struct packed {
        logic [2:0]                    len;
        logic [MID_MAX-1:0][7:0]       bytes;
    } t_text;

    // One input byte's worth of output: replacements, literal run, replacements
    typedef struct packed {
        logic [1:0]                    pre_repl;
        logic [2:0]                    mid_len;
        logic [MID_MAX-1:0][7:0]       mid;
        logic [1:0]                    post_repl;
        logic                          fin;
    } t_job;

    // Front to queue
    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        if ((b >= PRINT_LO && b <= PRINT_HI) || b == BYTE_TAB || b == BYTE_LF
            || b == BYTE_CR) begin
            c = CLS_TEXT;
        end else if (b >= CONT_LO && b <= CONT_HI) begin
            c = CLS_CONT;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            c = CLS_LEAD2;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            c = CLS_LEAD3;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

    // Text byte to its escaped form
    function automatic t_text escape_text(input logic [7:0] b);
        t_text r;
        r       = '0;
        r.len   = 3'd1;
        r.bytes[0] = b;
        unique case (b)
            CHAR_AMP: begin // &amp;
                r.len = 3'd5;
                r.bytes[0] = CHAR_AMP; r.bytes[1] = 8'h61; r.bytes[2] = 8'h6D;
                r.bytes[3] = 8'h70;    r.bytes[4] = CHAR_SEMI;
            end
            CHAR_LT: begin // &lt;
                r.len = 3'd4;
                r.bytes[0] = CHAR_AMP; r.bytes[1] = 8'h6C; r.bytes[2] = 8'h74;
                r.bytes[3] = CHAR_SEMI;
            end
            CHAR_GT: begin // &gt;
                r.len = 3'd4;
                r.bytes[0] = CHAR_AMP; r.bytes[1] = 8'h67; r.bytes[2] = 8'h74;
                r.bytes[3] = CHAR_SEMI;
            end
            CHAR_QUOT: begin // &quot;
                r.len = 3'd6;
                r.bytes[0] = CHAR_AMP; r.bytes[1] = 8'h71; r.bytes[2] = 8'h75;
                r.bytes[3] = 8'h6F;    r.bytes[4] = 8'h74; r.bytes[5] = CHAR_SEMI;
            end
            CHAR_APOS: begin // &apos;
                r.len = 3'd6;
                r.bytes[0] = CHAR_AMP; r.bytes[1] = 8'h61; r.bytes[2] = 8'h70;
                r.bytes[3] = 8'h6F;    r.bytes[4] = 8'h73; r.bytes[5] = CHAR_SEMI;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Times three on a 2-bit count
    function automatic logic [3:0] mul3(input logic [1:0] x);
        return {1'b0, x, 1'b0} + {2'b00, x};
    endfunction

    // Byte of a run of replacement characters at a given offset
    function automatic logic [7:0] repl_byte(input logic [3:0] off);
        logic [7:0] r;
        unique case (off)
            4'd0, 4'd3, 4'd6, 4'd9:  r = REPL_0;
            4'd1, 4'd4, 4'd7, 4'd10: r = REPL_1;
            default:                 r = REPL_2;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/utf8_sanitizing_xml_escaper_top.sv
// Top level of the UTF-8 sanitising XML escaper.
// Takes text one byte per transaction and returns an XML-escaped stream in
// which every malformed UTF-8 byte is replaced by U+FFFD. Plain text is taken
// at one byte per cycle. A byte that is only held as part of a pending sequence
// produces no output, and the byte that completes the sequence sends all of it
// (two to four bytes), so well-formed UTF-8 also averages one byte per cycle.
// An input byte that yields N output bytes (an entity, or the replacements for
// a broken or unfinished sequence, up to 15 bytes) goes out as N transactions,
// since the emitter sends one byte per cycle. The first output byte of an
// input transaction passes the job queue and the emitter's job register before
// it can be taken. A queue of QUEUE_DEPTH jobs sits between the front end and
// the emitter, so the input keeps flowing while the output stalls or while a
// long entity or replacement run drains, until the queue is full; o_stall is
// then high. There is no configuration and no start-up sweep after reset.
module utf8_sanitizing_xml_escaper_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  usxe_pkg::t_in_item  i_in_item,
    output logic                o_valid,
    input  logic                i_stall,
    output usxe_pkg::t_out_item o_out_item
);
    import usxe_pkg::*;

    t_push queue_push;
    t_job  queue_job;
    logic  queue_full, queue_valid, queue_pop;

    // Classify input and build jobs
    usxe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_item    (i_in_item),
        .o_stall      (o_stall),
        .i_queue_full (queue_full),
        .o_push       (queue_push)
    );

    // Job queue
    usxe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    // Expand jobs into output bytes
    usxe_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (queue_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### hw/rtl/usxe_front.sv
// Front end: accepts input bytes, tracks pending UTF-8 sequences, builds jobs.
module usxe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  usxe_pkg::t_in_item i_in_item,
    output logic              o_stall,
    input  logic              i_queue_full,
    output usxe_pkg::t_push   o_push
);
    import usxe_pkg::*;

    logic [7:0]  r_held [0:2];
    logic [7:0]  n_held [0:2];
    logic [1:0]  r_cnt, n_cnt;
    logic [2:0]  r_len, n_len;

    logic        accept;
    logic [7:0]  b;
    logic        fin;
    t_byte_class cls;
    t_text       esc;
    t_job        job;
    logic        fresh;

    assign b      = i_in_item.in_byte;
    assign fin    = i_in_item.final_byte;
    assign cls    = classify(b);
    assign esc    = escape_text(b);
    assign accept = i_valid && !i_queue_full;
    assign o_stall = i_queue_full;

    // Sequence tracking and job assembly
    always_comb begin
        job   = '0;
        n_held = r_held;
        n_cnt = r_cnt;
        n_len = r_len;
        fresh = 1'b0;

        if (r_cnt != 2'd0 && cls == CLS_CONT) begin
            if (({1'b0, r_cnt} + 3'd1) >= r_len) begin
                // sequence complete: copy held bytes and this one
                for (int k = 0; k < 3; k++) begin
                    if (k < int'(r_cnt)) begin
                        job.mid[k] = r_held[k];
                    end
                end
                job.mid[{1'b0, r_cnt}] = b;
                job.mid_len = {1'b0, r_cnt} + 3'd1;
                n_cnt = 2'd0;
                n_len = 3'd0;
            end else begin
                n_held[r_cnt] = b;
                n_cnt = r_cnt + 2'd1;
            end
        end else begin
            // broken sequence (if any) is flushed ahead of this byte
            job.pre_repl = r_cnt;
            fresh = 1'b1;
        end

        if (fresh) begin
            n_cnt = 2'd0;
            n_len = 3'd0;
            unique case (cls)
                CLS_TEXT: begin
                    job.mid_len = esc.len;
                    job.mid     = esc.bytes;
                end
                CLS_LEAD2: begin
                    n_held[0] = b; n_cnt = 2'd1; n_len = SEQ_LEN_2;
                end
                CLS_LEAD3: begin
                    n_held[0] = b; n_cnt = 2'd1; n_len = SEQ_LEN_3;
                end
                CLS_LEAD4: begin
                    n_held[0] = b; n_cnt = 2'd1; n_len = SEQ_LEN_4;
                end
                default: begin
                    job.mid_len = 3'd3;
                    job.mid[0]  = REPL_0;
                    job.mid[1]  = REPL_1;
                    job.mid[2]  = REPL_2;
                end
            endcase
        end

        // end of text flushes whatever is still pending
        if (fin) begin
            job.post_repl = n_cnt;
            n_cnt = 2'd0;
            n_len = 3'd0;
        end
        job.fin = fin;
    end

    assign o_push.job  = job;
    assign o_push.push = accept && (job.pre_repl != 2'd0 || job.mid_len != 3'd0
                                    || job.post_repl != 2'd0);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_len <= 3'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_len <= n_len;
        end
    end

    // Held sequence bytes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

### hw/rtl/usxe_queue.sv
// Short job queue between the front end and the emitter.
module usxe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  usxe_pkg::t_push i_push,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output usxe_pkg::t_job  o_job
);
    import usxe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job              r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

### hw/rtl/usxe_emit.sv
// Back end: expands a job into output bytes, one per cycle unless stalled.
module usxe_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  usxe_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output usxe_pkg::t_out_item o_out_item
);
    import usxe_pkg::*;

    t_job        r_job;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic [3:0]  r_last_idx;

    logic        take, is_last, load_ok;
    logic [3:0]  seg_a, seg_b, mid_off, post_off, job_len;
    logic [7:0]  byte_sel;

    assign take    = r_busy && !i_stall;
    assign is_last = (r_idx == r_last_idx);
    assign load_ok = !r_busy || (take && is_last);
    assign o_pop   = load_ok && i_job_valid;

    // Total output bytes of the incoming job
    assign job_len = mul3(i_job.pre_repl) + {1'b0, i_job.mid_len} + mul3(i_job.post_repl);

    // Segment boundaries of the current job
    assign seg_a    = mul3(r_job.pre_repl);
    assign seg_b    = seg_a + {1'b0, r_job.mid_len};
    assign mid_off  = r_idx - seg_a;
    assign post_off = r_idx - seg_b;

    // Byte select: leading replacements, literal run, trailing replacements
    always_comb begin
        if (r_idx < seg_a) begin
            byte_sel = repl_byte(r_idx);
        end else if (r_idx < seg_b) begin
            byte_sel = r_job.mid[mid_off[2:0]];
        end else begin
            byte_sel = repl_byte(post_off);
        end
    end

    assign o_valid                = r_busy;
    assign o_out_item.out_byte    = byte_sel;
    assign o_out_item.last_of_run = is_last;
    assign o_out_item.end_of_text = is_last && r_job.fin;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 4'd0;
        end else if (take && is_last) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx  <= r_idx + 4'd1;
        end
    end

    // Current job
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job      <= i_job;
            r_last_idx <= job_len - 4'd1;
        end
    end

endmodule

### dv/utf8_sanitizing_xml_escaper_top_test.sv
// Self-checking testbench for the UTF-8 sanitising XML escaper top level.
`timescale 1ns / 100ps

module utf8_sanitizing_xml_escaper_top_test;
    import usxe_pkg::*;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      i_valid   = 1'b0;
    logic      i_stall   = 1'b0;
    t_in_item  i_in_item = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_out_item;

    utf8_sanitizing_xml_escaper_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_item  (i_in_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_item (o_out_item)
    );

    // Bytes waiting to be sent and output bytes still owed by the block
    t_in_item  pending_q[$];
    t_out_item escaped_q[$];

    // Shadow of the pending multi-byte sequence
    logic [7:0] pend_bytes [3];
    logic [1:0] pend_count = 2'd0;
    logic [2:0] pend_len   = 3'd0;

    logic in_taken    = 1'b0;
    logic idle_on     = 1'b1;
    int   hold_asks   = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   fault_count = 0;
    int   queued_items = 0;

    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 20;

    // Clock, period 20 ns
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic void emit(logic [7:0] b);
        t_out_item r;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        r.end_of_text = 1'b0;
        escaped_q.push_back(r);
    endfunction

    function automatic void emit_text(string s);
        for (int k = 0; k < s.len(); k++)
            emit(s[k]);
    endfunction

    function automatic void emit_repl();
        emit(REPL_0);
        emit(REPL_1);
        emit(REPL_2);
    endfunction

    // Every held byte turns into one replacement character
    function automatic void flush_pending();
        for (int k = 0; k < pend_count; k++)
            emit_repl();
        pend_count = 2'd0;
        pend_len   = 3'd0;
    endfunction

    // Byte handled with nothing held
    function automatic void take_fresh(logic [7:0] b);
        if ((b >= PRINT_LO && b <= PRINT_HI) || b == BYTE_TAB || b == BYTE_LF
            || b == BYTE_CR) begin
            case (b)
                CHAR_AMP:  emit_text("&amp;");
                CHAR_LT:   emit_text("&lt;");
                CHAR_GT:   emit_text("&gt;");
                CHAR_QUOT: emit_text("&quot;");
                CHAR_APOS: emit_text("&apos;");
                default:   emit(b);
            endcase
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            pend_bytes[0] = b;
            pend_count    = 2'd1;
            pend_len      = SEQ_LEN_2;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            pend_bytes[0] = b;
            pend_count    = 2'd1;
            pend_len      = SEQ_LEN_3;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            pend_bytes[0] = b;
            pend_count    = 2'd1;
            pend_len      = SEQ_LEN_4;
        end else begin
            emit_repl();
        end
    endfunction

    // Expected output bytes for one accepted input byte
    function automatic void escape_byte(logic [7:0] b, logic fin);
        int        first;
        t_out_item r;
        first = escaped_q.size();
        if (pend_count != 2'd0) begin
            if (b >= CONT_LO && b <= CONT_HI) begin
                if (int'(pend_count) + 1 >= int'(pend_len)) begin
                    // sequence complete, copy it through
                    for (int k = 0; k < pend_count; k++)
                        emit(pend_bytes[k]);
                    emit(b);
                    pend_count = 2'd0;
                    pend_len   = 3'd0;
                end else if (pend_count < 2'd3) begin
                    pend_bytes[pend_count] = b;
                    pend_count = pend_count + 2'd1;
                end else begin
                    flush_pending();
                    take_fresh(b);
                end
            end else begin
                // broken sequence: replace what is held, then start afresh
                flush_pending();
                take_fresh(b);
            end
        end else begin
            take_fresh(b);
        end
        if (fin && pend_count != 2'd0)
            flush_pending();
        if (escaped_q.size() > first) begin
            r = escaped_q.pop_back();
            r.last_of_run = 1'b1;
            r.end_of_text = fin;
            escaped_q.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b, logic fin);
        t_in_item it;
        it.in_byte    = b;
        it.final_byte = fin;
        pending_q.push_back(it);
        queued_items++;
    endfunction

    function automatic logic rand_fin();
        return ($urandom_range(0, 24) == 0);
    endfunction

    // One random token: mostly text and well-formed sequences, some noise
    function automatic void add_token();
        int         kind;
        int         len;
        int         keep;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       add_byte(CHAR_AMP, rand_fin());
                    1:       add_byte(CHAR_LT, rand_fin());
                    2:       add_byte(CHAR_GT, rand_fin());
                    3:       add_byte(CHAR_QUOT, rand_fin());
                    default: add_byte(CHAR_APOS, rand_fin());
                endcase
            end else begin
                add_byte(8'($urandom_range(PRINT_LO, PRINT_HI)), rand_fin());
            end
        end else if (kind < 45) begin
            case ($urandom_range(0, 2))
                0:       add_byte(BYTE_TAB, rand_fin());
                1:       add_byte(BYTE_LF, rand_fin());
                default: add_byte(BYTE_CR, rand_fin());
            endcase
        end else if (kind < 88) begin
            len = $urandom_range(2, 4);
            case (len)
                2:       lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
                3:       lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
            endcase
            // complete sequence, or a truncated one that the next token breaks
            keep = (kind < 75) ? len - 1 : $urandom_range(0, len - 2);
            add_byte(lead, rand_fin());
            for (int k = 0; k < keep; k++)
                add_byte(8'($urandom_range(CONT_LO, CONT_HI)), rand_fin());
        end else begin
            add_byte(8'($urandom_range(0, 255)), rand_fin());
        end
    endfunction

    task automatic queue_random(int n);
        int target;
        target = queued_items + n;
        while (queued_items < target)
            add_token();
    endtask

    // All queued bytes accepted and valid dropped
    task automatic wait_sent();
        do @(posedge i_clk); while (pending_q.size() != 0 || i_valid);
    endtask

    // Every expected output byte has arrived
    task automatic wait_results();
        do @(negedge i_clk); while (escaped_q.size() != 0);
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Driver: presents the next pending byte, idles now and then
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_in_item <= '0;
        end else if (!i_valid || in_taken) begin
            if (pending_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 10)) begin
                i_valid   <= 1'b1;
                i_in_item <= pending_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(0, 99) < 10);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on input transactions, checks output ones
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall)
                escape_byte(i_in_item.in_byte, i_in_item.final_byte);
            if (o_valid && !i_stall) begin
                if (escaped_q.size() == 0) begin
                    if (fault_count < 10)
                        $display("%0t: unexpected output byte %h last %b end %b", $time,
                                 o_out_item.out_byte, o_out_item.last_of_run,
                                 o_out_item.end_of_text);
                    fault_count++;
                end else begin
                    want = escaped_q.pop_front();
                    if (want.out_byte !== o_out_item.out_byte
                        || want.last_of_run !== o_out_item.last_of_run
                        || want.end_of_text !== o_out_item.end_of_text) begin
                        if (fault_count < 10)
                            $display("%0t: mismatch exp byte %h last %b end %b, got %h %b %b",
                                     $time, want.out_byte, want.last_of_run,
                                     want.end_of_text, o_out_item.out_byte,
                                     o_out_item.last_of_run, o_out_item.end_of_text);
                        fault_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence of phases
    // ---------------------------------------------------------------
    initial begin
        int spin;
        pend_bytes = '{8'h00, 8'h00, 8'h00};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every escape, strays and the sequence cases
        add_byte(8'h00, 1'b0);
        add_byte(BYTE_TAB, 1'b0);
        add_byte(BYTE_LF, 1'b0);
        add_byte(BYTE_CR, 1'b0);
        add_byte(CHAR_AMP, 1'b0);
        add_byte(CHAR_LT, 1'b0);
        add_byte(CHAR_GT, 1'b0);
        add_byte(CHAR_QUOT, 1'b0);
        add_byte(CHAR_APOS, 1'b0);
        add_byte(PRINT_HI, 1'b1);
        add_byte(CONT_LO, 1'b0);
        add_byte(8'hC1, 1'b0);
        add_byte(8'hF5, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(LEAD2_LO, 1'b0);
        add_byte(CONT_LO, 1'b0);
        add_byte(LEAD4_HI, 1'b0);
        add_byte(8'h8F, 1'b0);
        add_byte(CONT_HI, 1'b0);
        add_byte(CONT_HI, 1'b0);
        // broken three-byte sequence
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'h41, 1'b0);
        // unfinished at the end of the text
        add_byte(LEAD4_LO, 1'b0);
        add_byte(8'h90, 1'b1);
        wait_sent();
        wait_results();

        // Random traffic with idling on both sides
        queue_random(130);
        wait_sent();

        // Long receiver hold-off while the sender keeps going
        queue_random(60);
        hold_asks = hold_asks + 1;
        wait_sent();
        // sender pauses until the block has drained
        wait_results();

        // Stretch with no idling at all
        idle_on = 1'b0;
        queue_random(80);
        wait_sent();
        idle_on = 1'b1;

        queue_random(75);
        wait_sent();

        // Drain and let the tail settle
        spin = 0;
        while (escaped_q.size() != 0 && spin < 5000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (escaped_q.size() != 0) begin
            if (fault_count < 10)
                $display("%0t: %0d expected output bytes never arrived", $time,
                         escaped_q.size());
            fault_count++;
        end

        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
